@@ src/slss_pkg.sv @@
`timescale 1ns / 1ps
package slss_pkg;
    localparam int MAX_VARS    = 8;
    localparam int MAX_CLAUSES = 64;
    localparam int MAX_TABU    = 8;
    localparam int VAR_W       = $clog2(MAX_VARS + 1);
    localparam int SLOT_W      = $clog2(MAX_CLAUSES);
    localparam int CNT_W       = $clog2(MAX_CLAUSES + 1);

    localparam logic [1:0] CMD_LOAD_CLAUSE = 2'd0;
    localparam logic [1:0] CMD_LOAD_ASSIGN = 2'd1;
    localparam logic [1:0] CMD_STEP        = 2'd2;
    localparam logic [1:0] CMD_UNUSED      = 2'd3;

    localparam logic [2:0] ST_LOADED  = 3'd0;
    localparam logic [2:0] ST_SOLVED  = 3'd1;
    localparam logic [2:0] ST_FLIPPED = 3'd2;
    localparam logic [2:0] ST_NO_FLIP = 3'd3;
    localparam logic [2:0] ST_LIMIT   = 3'd4;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_VARS    = 3'd1;
    localparam logic [2:0] REG_CLAUSES = 3'd2;
    localparam logic [2:0] REG_TABU    = 3'd3;
    localparam logic [2:0] REG_LIMIT   = 3'd4;
endpackage

@@ src/sat_local_search_step_unit.sv @@
`timescale 1ns / 1ps
// loads and unused commands run a single recount scan over the clauses before the result
// a step scans once to count, once at the end
// walk adds a 16-bit remainder for the clause index, a select scan and one for the variable index
// greedy adds a scan per candidate and skips each tabu candidate without a scan
// one item at a time, next accept in the cycle after the result is registered; a waiting result
// does not block the input; reset clears assignment, tabu ring, step counter, registers only
module sat_local_search_step_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    output logic        stall_in,
    input  logic [1:0]  command,
    input  logic [5:0]  clause_slot,
    input  logic [7:0]  positive_mask,
    input  logic [7:0]  negative_mask,
    input  logic [7:0]  start_assignment,
    input  logic [15:0] pick_clause_random,
    input  logic [15:0] pick_var_random,
    output logic        valid_out,
    input  logic        stall_out,
    output logic [2:0]  status,
    output logic [3:0]  flipped_variable,
    output logic [6:0]  unsatisfied_count,
    output logic [7:0]  assignment_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import slss_pkg::*;

    // phases of one item
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_COUNT  = 7'b0000010,  // count unsat under current assignment
        S_SELECT = 7'b0000100,  // walk: find the k-th unsat clause
        S_MOD    = 7'b0001000,  // walk: remainders of the random words, one bit a cycle
        S_GREEDY = 7'b0010000,  // greedy: one scan per candidate that is not tabu
        S_FINAL  = 7'b0100000,  // recount after the step or load
        S_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic        mode_reg;
    logic [3:0]  vars_reg;
    logic [6:0]  clauses_reg;
    logic [2:0]  tabu_len_reg;
    logic [15:0] limit_reg;

    // search state
    logic [7:0]  assign_reg;
    logic [VAR_W-1:0] tabu_reg [MAX_TABU];
    logic [15:0] steps_reg;

    // clause memory, one read port registered
    logic [15:0] clause_mem [MAX_CLAUSES];
    logic [15:0] rd_data;
    logic [SLOT_W-1:0] rd_addr;

    // item registers
    logic [15:0] rc_reg, rv_reg;
    logic [2:0]  status_reg;
    logic [3:0]  flip_reg;
    logic        out_valid_reg;

    // result register, parts the waiting result from the next item
    logic [2:0]  out_status_reg;
    logic [3:0]  out_flip_reg;
    logic [CNT_W-1:0] unsat_reg;
    logic [7:0]  out_assign_reg;

    // scan control: addr issued, data arrives in the next cycle
    logic [CNT_W-1:0] scan_idx_reg;     // next address to issue
    logic        scan_live_reg;         // rd_data holds a clause of this scan
    logic [CNT_W-1:0] acc_reg;          // unsat count of scan
    logic [CNT_W-1:0] u_reg;            // unsat before step
    logic [7:0]  probe_reg;             // assignment under test
    logic [3:0]  cand_reg;              // greedy candidate
    logic        found_reg;
    logic [CNT_W-1:0] best_reg;
    logic [3:0]  best_var_reg;
    logic [15:0] pick_lits_reg;
    logic        mod_phase_reg;         // 0 clause index, 1 variable index
    logic [4:0]  div_cnt_reg;           // remainder bits still to do
    logic [7:0]  div_rem_reg;           // partial remainder

    logic [3:0]  eff_vars;
    logic [CNT_W-1:0] eff_clauses;
    logic [3:0]  eff_tabu;
    logic [7:0]  vmask;

    assign eff_vars    = (vars_reg > 4'(MAX_VARS)) ? 4'(MAX_VARS) : vars_reg;
    assign eff_clauses = (clauses_reg > 7'(MAX_CLAUSES)) ? CNT_W'(MAX_CLAUSES)
                                                         : CNT_W'(clauses_reg);
    assign eff_tabu    = 4'(tabu_len_reg);
    assign vmask       = 8'((9'd1 << eff_vars) - 9'd1);

    logic clause_sat;
    assign clause_sat = (((rd_data[7:0] & probe_reg) | (rd_data[15:8] & ~probe_reg))
                         & vmask) != 8'd0;

    logic scan_done;
    assign scan_done = (scan_idx_reg >= eff_clauses) && !scan_live_reg;

    logic [CNT_W-1:0] acc_sum;
    assign acc_sum = acc_reg + CNT_W'(scan_live_reg && !clause_sat);

    // tabu test for the current candidate
    logic cand_tabu;
    always_comb
    begin
        cand_tabu = 1'b0;
        for (int j = 0; j < MAX_TABU; j++)
        begin
            if ((4'(j) < eff_tabu) && (tabu_reg[j] == VAR_W'(cand_reg)))
                cand_tabu = 1'b1;
        end
    end

    // literals of picked clause, their count and j-th position
    logic [7:0] lits;
    logic [3:0] lits_n;
    logic [3:0] jth_var;
    logic [3:0] seen;
    assign lits = (pick_lits_reg[7:0] | pick_lits_reg[15:8]) & vmask;
    always_comb
    begin
        lits_n  = 4'd0;
        seen    = 4'd0;
        jth_var = 4'(MAX_VARS);
        for (int i = 0; i < MAX_VARS; i++)
            lits_n = lits_n + 4'(lits[i]);
        for (int i = 0; i < MAX_VARS; i++)
        begin
            if (lits[i])
            begin
                if (seen == rv_reg[3:0] && jth_var == 4'(MAX_VARS))
                    jth_var = 4'(i);
                seen = seen + 4'd1;
            end
        end
    end

    // restoring remainder step, dividend msb first; remainder stays below the divisor
    logic [15:0] div_src;
    logic [7:0]  div_den;
    logic [7:0]  div_trial;
    logic [7:0]  div_rem_next;
    assign div_src      = mod_phase_reg ? rv_reg : rc_reg;
    assign div_den      = mod_phase_reg ? 8'(lits_n) : 8'(u_reg);
    assign div_trial    = {div_rem_reg[6:0], div_src[15]};
    assign div_rem_next = (div_trial >= div_den) ? div_trial - div_den : div_trial;

    assign stall_in = (state_reg != S_IDLE);
    logic accept;
    assign accept = valid_in && !stall_in;

    assign rd_addr = scan_idx_reg[SLOT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (accept && command == CMD_LOAD_CLAUSE)
            clause_mem[clause_slot] <= {negative_mask & ~positive_mask, positive_mask};
        rd_data <= clause_mem[rd_addr];
    end

    logic scan_issue;
    assign scan_issue = scan_idx_reg < eff_clauses;

    // state machine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            assign_reg     <= 8'd0;
            steps_reg      <= 16'd0;
            scan_live_reg  <= 1'b0;
            scan_idx_reg   <= '0;
            rc_reg         <= 16'd0;
            rv_reg         <= 16'd0;
            status_reg     <= ST_LOADED;
            flip_reg       <= 4'(MAX_VARS);
            out_status_reg <= ST_LOADED;
            out_flip_reg   <= 4'(MAX_VARS);
            unsat_reg      <= '0;
            out_assign_reg <= 8'd0;
            acc_reg        <= '0;
            u_reg          <= '0;
            probe_reg      <= 8'd0;
            cand_reg       <= 4'd0;
            found_reg      <= 1'b0;
            best_reg       <= '0;
            best_var_reg   <= 4'd0;
            pick_lits_reg  <= 16'd0;
            mod_phase_reg  <= 1'b0;
            div_cnt_reg    <= 5'd0;
            div_rem_reg    <= 8'd0;
            for (int j = 0; j < MAX_TABU; j++)
                tabu_reg[j] <= VAR_W'(MAX_VARS);
        end
        else
        begin
            if (out_valid_reg && !stall_out)
                out_valid_reg <= 1'b0;
            scan_live_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        rc_reg       <= pick_clause_random;
                        rv_reg       <= pick_var_random;
                        status_reg   <= ST_LOADED;
                        flip_reg     <= 4'(MAX_VARS);
                        acc_reg      <= '0;
                        scan_idx_reg <= '0;
                        if (command == CMD_LOAD_ASSIGN)
                        begin
                            assign_reg <= start_assignment;
                            probe_reg  <= start_assignment;
                            steps_reg  <= 16'd0;
                            for (int j = 0; j < MAX_TABU; j++)
                                tabu_reg[j] <= VAR_W'(MAX_VARS);
                        end
                        else
                            probe_reg <= assign_reg;
                        state_reg <= (command == CMD_STEP) ? S_COUNT : S_FINAL;
                    end
                end
                S_COUNT, S_FINAL, S_SELECT, S_GREEDY:
                begin
                    if (scan_issue)
                    begin
                        scan_idx_reg  <= scan_idx_reg + 1'b1;
                        scan_live_reg <= 1'b1;
                    end
                    acc_reg <= acc_sum;
                    if (state_reg == S_SELECT && scan_live_reg && !clause_sat)
                    begin
                        // k-th unsat clause found when running count equals k
                        if (acc_reg == CNT_W'(rc_reg))
                        begin
                            pick_lits_reg <= rd_data;
                            state_reg     <= S_MOD;
                            mod_phase_reg <= 1'b1;
                            div_cnt_reg   <= 5'd16;
                            div_rem_reg   <= 8'd0;
                        end
                    end
                    if (scan_done && !(state_reg == S_SELECT))
                    begin
                        acc_reg      <= '0;
                        scan_idx_reg <= '0;
                        priority case (1'b1)
                            (state_reg == S_FINAL):
                            begin
                                if (!out_valid_reg || !stall_out)
                                begin
                                    out_status_reg <= status_reg;
                                    out_flip_reg   <= flip_reg;
                                    unsat_reg      <= acc_reg;
                                    out_assign_reg <= assign_reg;
                                    out_valid_reg  <= 1'b1;
                                    state_reg      <= S_IDLE;
                                end
                                else
                                begin
                                    // result register still full, keep the count
                                    acc_reg      <= acc_reg;
                                    scan_idx_reg <= scan_idx_reg;
                                end
                            end
                            (state_reg == S_COUNT):
                            begin
                                u_reg <= acc_reg;
                                if (acc_reg == '0)
                                begin
                                    status_reg <= ST_SOLVED;
                                    state_reg  <= S_FINAL;
                                end
                                else if (steps_reg >= limit_reg)
                                begin
                                    status_reg <= ST_LIMIT;
                                    state_reg  <= S_FINAL;
                                end
                                else
                                begin
                                    if (steps_reg != 16'hFFFF)
                                        steps_reg <= steps_reg + 16'd1;
                                    if (!mode_reg)
                                    begin
                                        state_reg     <= S_MOD;
                                        mod_phase_reg <= 1'b0;
                                        div_cnt_reg   <= 5'd16;
                                        div_rem_reg   <= 8'd0;
                                    end
                                    else
                                    begin
                                        cand_reg  <= 4'd0;
                                        found_reg <= 1'b0;
                                        state_reg <= S_GREEDY;
                                        probe_reg <= assign_reg ^ 8'd1;
                                    end
                                end
                            end
                            default:
                            begin
                                // greedy candidate scored
                                if (!cand_tabu && cand_reg < eff_vars
                                    && (!found_reg || acc_reg < best_reg))
                                begin
                                    best_reg     <= acc_reg;
                                    best_var_reg <= cand_reg;
                                    found_reg    <= 1'b1;
                                end
                                cand_reg  <= cand_reg + 4'd1;
                                probe_reg <= assign_reg ^ 8'(9'd2 << cand_reg);
                                if (cand_reg + 4'd1 >= eff_vars)
                                    state_reg <= S_MOD;
                            end
                        endcase
                    end
                    // greedy: skip tabu candidate without scanning
                    if (state_reg == S_GREEDY && (cand_tabu || cand_reg >= eff_vars)
                        && scan_idx_reg == '0 && !scan_live_reg && !scan_done)
                    begin
                        scan_idx_reg  <= '0;
                        scan_live_reg <= 1'b0;
                        acc_reg       <= '0;
                        cand_reg      <= cand_reg + 4'd1;
                        probe_reg     <= assign_reg ^ 8'(9'd2 << cand_reg);
                        if (cand_reg + 4'd1 >= eff_vars)
                            state_reg <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    if (mode_reg)
                    begin
                        // greedy wrap-up
                        if (found_reg)
                        begin
                            assign_reg <= assign_reg ^ 8'(9'd1 << best_var_reg);
                            probe_reg  <= assign_reg ^ 8'(9'd1 << best_var_reg);
                            flip_reg   <= best_var_reg;
                            status_reg <= ST_FLIPPED;
                            for (int j = MAX_TABU - 1; j > 0; j--)
                                tabu_reg[j] <= tabu_reg[j-1];
                            tabu_reg[0] <= VAR_W'(best_var_reg);
                        end
                        else
                        begin
                            status_reg <= ST_NO_FLIP;
                            probe_reg  <= assign_reg;
                        end
                        state_reg <= S_FINAL;
                    end
                    else if (div_cnt_reg != 5'd0)
                    begin
                        // one remainder bit a cycle, the last one leaves the remainder
                        div_cnt_reg <= div_cnt_reg - 5'd1;
                        div_rem_reg <= div_rem_next;
                        if (!mod_phase_reg)
                            rc_reg <= (div_cnt_reg == 5'd1) ? 16'(div_rem_next)
                                                            : {rc_reg[14:0], 1'b0};
                        else
                            rv_reg <= (div_cnt_reg == 5'd1) ? 16'(div_rem_next)
                                                            : {rv_reg[14:0], 1'b0};
                    end
                    else if (!mod_phase_reg)
                    begin
                        probe_reg <= assign_reg;
                        state_reg <= S_SELECT;
                    end
                    else if (lits_n == 4'd0)
                    begin
                        status_reg <= ST_NO_FLIP;
                        probe_reg  <= assign_reg;
                        state_reg  <= S_FINAL;
                        acc_reg    <= '0;
                        scan_idx_reg <= '0;
                    end
                    else
                    begin
                        assign_reg <= assign_reg ^ 8'(9'd1 << jth_var);
                        probe_reg  <= assign_reg ^ 8'(9'd1 << jth_var);
                        flip_reg   <= jth_var;
                        status_reg <= ST_FLIPPED;
                        state_reg  <= S_FINAL;
                        acc_reg    <= '0;
                        scan_idx_reg <= '0;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // configuration port
    assign pready = 1'b1;
    logic [2:0] reg_sel;
    assign reg_sel = paddr[4:2];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            vars_reg     <= 4'd8;
            clauses_reg  <= 7'd1;
            tabu_len_reg <= 3'd1;
            limit_reg    <= 16'd64;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                REG_MODE:    mode_reg     <= pwdata[0];
                REG_VARS:    vars_reg     <= pwdata[3:0];
                REG_CLAUSES: clauses_reg  <= pwdata[6:0];
                REG_TABU:    tabu_len_reg <= pwdata[2:0];
                REG_LIMIT:   limit_reg    <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_MODE:    prdata = {31'd0, mode_reg};
            REG_VARS:    prdata = {28'd0, vars_reg};
            REG_CLAUSES: prdata = {25'd0, clauses_reg};
            REG_TABU:    prdata = {29'd0, tabu_len_reg};
            REG_LIMIT:   prdata = {16'd0, limit_reg};
            default:     prdata = 32'd0;
        endcase
    end

    assign valid_out         = out_valid_reg;
    assign status            = out_status_reg;
    assign flipped_variable  = out_flip_reg;
    assign unsatisfied_count = 7'(unsat_reg);
    assign assignment_out    = out_assign_reg;

    // a stalled result holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_out && stall_out) |=> (valid_out && $stable(status)
            && $stable(flipped_variable) && $stable(unsatisfied_count)
            && $stable(assignment_out)))
        else $error("result changed while stalled");
    // a flip always names a real variable
    a_flip_var: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_FLIPPED) |-> (out_flip_reg < 4'(MAX_VARS)))
        else $error("flip without variable");
    // step counter holds while idle with no accepted item
    a_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !accept) |=> $stable(steps_reg))
        else $error("step counter moved while idle");
endmodule
